/* src/pingrx_pkg.sv */
// ============================================================================
// pingrx_pkg
// Shared types and constants of the ping line receiver: character codes,
// line kinds, number parser phases and the line status handed to the
// classifier.
// ============================================================================
package pingrx_pkg;

    // Default limit on stored characters per line
    localparam int LINE_MAX_DEFAULT = 255;

    typedef logic [7:0] byte_t;

    // Character codes
    localparam byte_t CH_LF     = 8'h0A;
    localparam byte_t CH_CR     = 8'h0D;
    localparam byte_t CH_TAB    = 8'h09;
    localparam byte_t CH_SPACE  = 8'h20;
    localparam byte_t CH_TILDE  = 8'h7E;
    localparam byte_t CH_PLUS   = 8'h2B;
    localparam byte_t CH_MINUS  = 8'h2D;
    localparam byte_t CH_ZERO   = 8'h30;
    localparam byte_t CH_NINE   = 8'h39;
    localparam byte_t CH_E      = 8'h45;
    localparam byte_t CH_G      = 8'h47;
    localparam byte_t CH_H      = 8'h48;
    localparam byte_t CH_I      = 8'h49;
    localparam byte_t CH_L      = 8'h4C;
    localparam byte_t CH_N      = 8'h4E;
    localparam byte_t CH_O      = 8'h4F;
    localparam byte_t CH_P      = 8'h50;

    // Kind of a finished line
    typedef enum logic [2:0] {
        KIND_OTHER = 3'd0,
        KIND_PING  = 3'd1,
        KIND_PONG  = 3'd2,
        KIND_HELLO = 3'd3,
        KIND_BAD   = 3'd4
    } line_kind_t;

    // Number parser phase
    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } num_phase_t;

    // Status of the line collected so far
    typedef struct packed {
        logic            bad;
        logic            empty;
        logic            len_eq4;
        logic            len_ge4;
        logic            len_ge5;
        byte_t [4:0]     head;
    } line_info_t;

endpackage

/* src/pingrx_line_framer.sv */
// ============================================================================
// pingrx_line_framer
// Frames received bytes into lines: tracks the stored and trimmed lengths,
// the bad-line flag and the first five characters, and tells the number
// parser which bytes belong to the number field.
// ============================================================================
module pingrx_line_framer #(
    parameter int LINE_MAX = pingrx_pkg::LINE_MAX_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,      // byte taken from the input register
    input  pingrx_pkg::byte_t       rx_byte,
    output logic                    num_feed,  // byte goes to the number parser
    output pingrx_pkg::line_info_t  info
);

    localparam int CW = $clog2(LINE_MAX + 1);

    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          trim_reg, trim_next;
    logic                   bad_reg, bad_next;
    pingrx_pkg::byte_t      head_reg [5];

    logic                   is_lf;
    logic                   printable;
    logic                   has_room;
    logic                   store;

    // Classify the incoming byte
    assign is_lf     = (rx_byte == pingrx_pkg::CH_LF);
    assign printable = ((rx_byte >= pingrx_pkg::CH_SPACE) && (rx_byte <= pingrx_pkg::CH_TILDE))
                       || (rx_byte == pingrx_pkg::CH_CR) || (rx_byte == pingrx_pkg::CH_TAB);
    assign has_room  = (count_reg < CW'(LINE_MAX));
    assign store     = step && !is_lf && printable && has_room;
    assign num_feed  = store && (count_reg >= CW'(5));

    // Advance lengths and bad flag; clear on newline
    always_comb
    begin
        count_next = count_reg;
        trim_next  = trim_reg;
        bad_next   = bad_reg;
        if (step)
        begin
            if (is_lf)
            begin
                count_next = '0;
                trim_next  = '0;
                bad_next   = 1'b0;
            end
            else if (!printable || !has_room)
            begin
                bad_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + 1'b1;
                if ((rx_byte != pingrx_pkg::CH_CR) && (rx_byte != pingrx_pkg::CH_SPACE))
                begin
                    trim_next = count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            trim_reg  <= '0;
            bad_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            trim_reg  <= trim_next;
            bad_reg   <= bad_next;
        end
    end

    // Capture the first five characters; only read where written
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 5; i++)
        begin
            if (store && (count_reg == CW'(i)))
            begin
                head_reg[i] <= rx_byte;
            end
        end
    end

    // Summarize the line for the classifier
    always_comb
    begin
        info.bad     = bad_reg;
        info.empty   = (trim_reg == '0);
        info.len_eq4 = (trim_reg == CW'(4));
        info.len_ge4 = (trim_reg >= CW'(4));
        info.len_ge5 = (trim_reg >= CW'(5));
        for (int i = 0; i < 5; i++)
        begin
            info.head[i] = head_reg[i];
        end
    end

endmodule

/* src/pingrx_number_parser.sv */
// ============================================================================
// pingrx_number_parser
// Parses the decimal number after the keyword, one character per cycle
// while fed: skip whitespace, optional sign, digits saturating on overflow.
// ============================================================================
module pingrx_number_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              feed,     // character of the number field
    input  logic              clear,    // start a new line
    input  pingrx_pkg::byte_t rx_byte,
    output logic [31:0]       value     // number, saturated or modulo 2^32
);

    pingrx_pkg::num_phase_t phase_reg, phase_next;
    logic                   neg_reg, neg_next;
    logic                   ovf_reg, ovf_next;
    logic [31:0]            value_reg, value_next;

    logic                   is_ws;
    logic                   is_sign;
    logic                   is_digit;
    logic [3:0]             digit;
    logic [35:0]            product;

    // Decode the character and form value * 10 + digit
    assign is_ws    = (rx_byte == pingrx_pkg::CH_SPACE) || (rx_byte == pingrx_pkg::CH_TAB)
                      || (rx_byte == pingrx_pkg::CH_CR);
    assign is_sign  = (rx_byte == pingrx_pkg::CH_PLUS) || (rx_byte == pingrx_pkg::CH_MINUS);
    assign is_digit = (rx_byte >= pingrx_pkg::CH_ZERO) && (rx_byte <= pingrx_pkg::CH_NINE);
    assign digit    = 4'(rx_byte - pingrx_pkg::CH_ZERO);
    assign product  = ({4'b0, value_reg} << 3) + ({4'b0, value_reg} << 1) + {32'b0, digit};

    // Next phase and accumulator
    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        ovf_next   = ovf_reg;
        value_next = value_reg;
        if (clear)
        begin
            phase_next = pingrx_pkg::PH_SKIP;
            neg_next   = 1'b0;
            ovf_next   = 1'b0;
            value_next = '0;
        end
        else if (feed)
        begin
            unique case (phase_reg) inside
                pingrx_pkg::PH_SKIP:
                begin
                    if (is_sign)
                    begin
                        phase_next = pingrx_pkg::PH_SIGN;
                        neg_next   = (rx_byte == pingrx_pkg::CH_MINUS);
                    end
                    else if (is_digit)
                    begin
                        phase_next = pingrx_pkg::PH_DIGITS;
                        value_next = product[31:0];
                    end
                    else if (!is_ws)
                    begin
                        phase_next = pingrx_pkg::PH_DONE;
                    end
                end
                pingrx_pkg::PH_SIGN, pingrx_pkg::PH_DIGITS:
                begin
                    if (is_digit)
                    begin
                        phase_next = pingrx_pkg::PH_DIGITS;
                        if (product[35:32] != 4'b0)
                        begin
                            ovf_next   = 1'b1;
                            value_next = '1;
                        end
                        else
                        begin
                            value_next = product[31:0];
                        end
                    end
                    else
                    begin
                        phase_next = pingrx_pkg::PH_DONE;
                    end
                end
                pingrx_pkg::PH_DONE:
                begin
                    phase_next = pingrx_pkg::PH_DONE;
                end
                default:
                begin
                    phase_next = pingrx_pkg::PH_SKIP;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= pingrx_pkg::PH_SKIP;
            neg_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
            value_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            ovf_reg   <= ovf_next;
            value_reg <= value_next;
        end
    end

    // Final value: all ones on overflow, else signed value
    always_comb
    begin
        unique case (phase_reg) inside
            pingrx_pkg::PH_SKIP, pingrx_pkg::PH_SIGN:
            begin
                value = '0;
            end
            default:
            begin
                if (ovf_reg)
                begin
                    value = '1;
                end
                else if (neg_reg)
                begin
                    value = 32'd0 - value_reg;
                end
                else
                begin
                    value = value_reg;
                end
            end
        endcase
    end

endmodule

/* src/ping_line_receiver.sv */
// ============================================================================
// ping_line_receiver
// Receives serial bytes, frames lines on newline and reports each nonempty
// or bad line with its kind, sequence number and running counters.
// ============================================================================
// The block takes one byte per clock, while no newline waits, into an
// input register; a newline that closes a bad or nonempty line loads a
// result into the output register, which drives the master side. Bytes
// other than newline never wait in the input register, but a byte waits
// at the input behind a held newline. A newline waits only while an
// earlier result is still held on the master side, so with the master
// ready the sustained rate is one byte per cycle. The line kind travels
// on m_tuser. The counters on the master side are the block's live
// counters; they only change when a new result is loaded.
module ping_line_receiver #(
    parameter int LINE_MAX = pingrx_pkg::LINE_MAX_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,    // [7:0] rx_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [159:0] m_tdata,    // [31:0] seq_number, [63:32] good_lines,
                                     // [95:64] bad_lines, [127:96] pings_seen,
                                     // [159:128] pongs_seen
    output logic [2:0]   m_tuser     // [2:0] line_kind
);

    logic                   in_valid_reg, in_valid_next;
    pingrx_pkg::byte_t      in_byte_reg;
    logic                   out_valid_reg, out_valid_next;
    pingrx_pkg::line_kind_t kind_reg, kind_next;
    logic [31:0]            seq_reg, seq_next;
    logic [31:0]            good_count_reg, good_count_next;
    logic [31:0]            bad_count_reg, bad_count_next;
    logic [31:0]            ping_count_reg, ping_count_next;
    logic [31:0]            pong_count_reg, pong_count_next;

    logic                   is_lf;
    logic                   out_free;
    logic                   advance;
    logic                   load;
    logic                   num_feed;
    logic [31:0]            num_value;
    pingrx_pkg::line_info_t info;
    logic                   pong_hit;
    logic                   ping_hit;
    logic                   hello_hit;

    // Handshake between input register and output register
    assign is_lf    = (in_byte_reg == pingrx_pkg::CH_LF);
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!is_lf || out_free);
    assign load     = advance && is_lf && (info.bad || !info.empty);
    assign s_tready = !in_valid_reg || advance;

    // Hold the accepted byte until it is processed
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    pingrx_line_framer #(
        .LINE_MAX (LINE_MAX)
    ) u_framer (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .rx_byte  (in_byte_reg),
        .num_feed (num_feed),
        .info     (info)
    );

    pingrx_number_parser u_number (
        .clk     (clk),
        .rst_n   (rst_n),
        .feed    (num_feed),
        .clear   (advance && is_lf),
        .rx_byte (in_byte_reg),
        .value   (num_value)
    );

    // Match the keywords at the head of the line
    assign pong_hit  = info.len_ge5
                       && (info.head[0] == pingrx_pkg::CH_P) && (info.head[1] == pingrx_pkg::CH_O)
                       && (info.head[2] == pingrx_pkg::CH_N) && (info.head[3] == pingrx_pkg::CH_G)
                       && (info.head[4] == pingrx_pkg::CH_SPACE);
    assign ping_hit  = info.len_ge4
                       && (info.head[0] == pingrx_pkg::CH_P) && (info.head[1] == pingrx_pkg::CH_I)
                       && (info.head[2] == pingrx_pkg::CH_N) && (info.head[3] == pingrx_pkg::CH_G)
                       && (info.len_eq4 || (info.head[4] == pingrx_pkg::CH_SPACE));
    assign hello_hit = info.len_ge5
                       && (info.head[0] == pingrx_pkg::CH_H) && (info.head[1] == pingrx_pkg::CH_E)
                       && (info.head[2] == pingrx_pkg::CH_L) && (info.head[3] == pingrx_pkg::CH_L)
                       && (info.head[4] == pingrx_pkg::CH_O);

    // Classify the line and advance the counters
    always_comb
    begin
        kind_next       = kind_reg;
        seq_next        = seq_reg;
        good_count_next = good_count_reg;
        bad_count_next  = bad_count_reg;
        ping_count_next = ping_count_reg;
        pong_count_next = pong_count_reg;
        if (load)
        begin
            seq_next = '0;
            if (info.bad)
            begin
                kind_next      = pingrx_pkg::KIND_BAD;
                bad_count_next = bad_count_reg + 32'd1;
            end
            else
            begin
                good_count_next = good_count_reg + 32'd1;
                if (pong_hit)
                begin
                    kind_next       = pingrx_pkg::KIND_PONG;
                    seq_next        = num_value;
                    pong_count_next = pong_count_reg + 32'd1;
                end
                else if (ping_hit)
                begin
                    kind_next       = pingrx_pkg::KIND_PING;
                    seq_next        = info.len_eq4 ? 32'd0 : num_value;
                    ping_count_next = ping_count_reg + 32'd1;
                end
                else if (hello_hit)
                begin
                    kind_next = pingrx_pkg::KIND_HELLO;
                end
                else
                begin
                    kind_next = pingrx_pkg::KIND_OTHER;
                end
            end
        end
    end

    // Output valid: set on load, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            good_count_reg <= '0;
            bad_count_reg  <= '0;
            ping_count_reg <= '0;
            pong_count_reg <= '0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            out_valid_reg  <= out_valid_next;
            good_count_reg <= good_count_next;
            bad_count_reg  <= bad_count_next;
            ping_count_reg <= ping_count_next;
            pong_count_reg <= pong_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        seq_reg  <= seq_next;
    end

    // Drive the master side
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {pong_count_reg, ping_count_reg, bad_count_reg,
                       good_count_reg, seq_reg};
    assign m_tuser  = kind_reg;

`ifndef SYNTHESIS
    // A bad line bumps the bad counter by one
    a_bad_count: assert property (@(posedge clk) disable iff (!rst_n)
        (load && info.bad) |=> (bad_count_reg == $past(bad_count_reg) + 32'd1))
        else $error("bad counter did not advance on dropped line");

    // Counters move only when a result is loaded
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !load |=> ($stable(good_count_reg) && $stable(bad_count_reg)
                   && $stable(ping_count_reg) && $stable(pong_count_reg)))
        else $error("counter changed without a result");

    // Only ping and pong results carry a number
    a_seq_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (kind_reg != pingrx_pkg::KIND_PING)
         && (kind_reg != pingrx_pkg::KIND_PONG)) |-> (seq_reg == 32'd0))
        else $error("nonzero number on a line without one");

    // A byte waiting in the input register holds until processed
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("input register lost a waiting byte");
`endif

endmodule

/* verif/tb_ping_line_receiver.sv */
// ============================================================================
// tb_ping_line_receiver
// Self-checking bench for the ping line receiver. Streams lines byte by byte
// (keywords, numbers at the overflow boundary, signs, trailing whitespace,
// control bytes, overlong lines, noise), predicts each line report and checks
// every master-side transaction field by field, with random gaps and stalls.
// ============================================================================
module tb_ping_line_receiver;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD = 10;
    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 20;
    localparam int RANDOM_BYTES = 350;

    // One expected line report
    typedef struct packed {
        pingrx_pkg::line_kind_t kind;
        logic [31:0]            seq;
        logic [31:0]            good;
        logic [31:0]            bad;
        logic [31:0]            pings;
        logic [31:0]            pongs;
    } line_report_t;

    // ------------------------------------------------------------------------
    // Line report predictor and checker
    // ------------------------------------------------------------------------
    class line_scoreboard;
        int unsigned            stored_cnt;
        int unsigned            trim_len;
        bit                     line_bad;
        pingrx_pkg::byte_t      head [5];
        logic [31:0]            num_val;
        pingrx_pkg::num_phase_t num_ph;
        bit                     num_neg;
        bit                     num_ovf;
        logic [31:0]            good_cnt;
        logic [31:0]            bad_cnt;
        logic [31:0]            ping_cnt;
        logic [31:0]            pong_cnt;
        line_report_t           reports_due [$];
        int unsigned            fail_count;

        function new();
            clear_line();
            good_cnt   = '0;
            bad_cnt    = '0;
            ping_cnt   = '0;
            pong_cnt   = '0;
            fail_count = 0;
        endfunction

        function void clear_line();
            stored_cnt = 0;
            trim_len   = 0;
            line_bad   = 1'b0;
            foreach (head[i]) head[i] = '0;
            num_val    = '0;
            num_ph     = pingrx_pkg::PH_SKIP;
            num_neg    = 1'b0;
            num_ovf    = 1'b0;
        endfunction

        // Advance the sequence number parser by one character past the head
        function void parse_char(pingrx_pkg::byte_t c);
            pingrx_pkg::num_phase_t ph;
            logic [63:0]            acc;
            ph = num_ph;
            if (ph == pingrx_pkg::PH_SKIP) begin
                if (c == pingrx_pkg::CH_SPACE || c == pingrx_pkg::CH_TAB
                    || c == pingrx_pkg::CH_CR)
                    return;
                if (c == pingrx_pkg::CH_PLUS || c == pingrx_pkg::CH_MINUS) begin
                    num_ph  = pingrx_pkg::PH_SIGN;
                    num_neg = (c == pingrx_pkg::CH_MINUS);
                    return;
                end
                ph = pingrx_pkg::PH_SIGN;
            end
            if (ph == pingrx_pkg::PH_SIGN || ph == pingrx_pkg::PH_DIGITS) begin
                if (c >= pingrx_pkg::CH_ZERO && c <= pingrx_pkg::CH_NINE) begin
                    acc = 64'(num_val) * 64'd10 + 64'(c - pingrx_pkg::CH_ZERO);
                    if (acc > 64'hFFFF_FFFF) begin
                        num_ovf = 1'b1;
                        acc     = 64'hFFFF_FFFF;
                    end
                    num_val = acc[31:0];
                    num_ph  = pingrx_pkg::PH_DIGITS;
                end
                else begin
                    num_ph = pingrx_pkg::PH_DONE;
                end
            end
        endfunction

        function logic [31:0] seq_value();
            if (num_ph == pingrx_pkg::PH_SKIP || num_ph == pingrx_pkg::PH_SIGN)
                return '0;
            if (num_ovf)
                return '1;
            if (num_neg)
                return 32'd0 - num_val;
            return num_val;
        endfunction

        function bit head_starts(string word);
            if (trim_len < word.len())
                return 1'b0;
            for (int i = 0; i < word.len(); i++)
                if (head[i] != pingrx_pkg::byte_t'(word[i]))
                    return 1'b0;
            return 1'b1;
        endfunction

        // Note one accepted byte; a newline that closes a bad or nonempty
        // line queues a report
        function void note_rx_byte(pingrx_pkg::byte_t c);
            line_report_t rep;
            if (c != pingrx_pkg::CH_LF) begin
                if (c != pingrx_pkg::CH_CR && c != pingrx_pkg::CH_TAB
                    && (c < pingrx_pkg::CH_SPACE || c > pingrx_pkg::CH_TILDE)) begin
                    line_bad = 1'b1;
                end
                else if (stored_cnt < pingrx_pkg::LINE_MAX_DEFAULT) begin
                    if (stored_cnt < 5)
                        head[stored_cnt] = c;
                    else
                        parse_char(c);
                    stored_cnt++;
                    if (c != pingrx_pkg::CH_CR && c != pingrx_pkg::CH_SPACE)
                        trim_len = stored_cnt;
                end
                else begin
                    line_bad = 1'b1;
                end
                return;
            end

            rep.seq = '0;
            if (line_bad) begin
                bad_cnt++;
                rep.kind = pingrx_pkg::KIND_BAD;
            end
            else if (trim_len == 0) begin
                clear_line();
                return;
            end
            else begin
                good_cnt++;
                if (head_starts("PONG ")) begin
                    rep.kind = pingrx_pkg::KIND_PONG;
                    rep.seq  = seq_value();
                    pong_cnt++;
                end
                else if (head_starts("PING")
                         && (trim_len == 4 || head[4] == pingrx_pkg::CH_SPACE)) begin
                    rep.kind = pingrx_pkg::KIND_PING;
                    rep.seq  = (trim_len == 4) ? 32'd0 : seq_value();
                    ping_cnt++;
                end
                else if (head_starts("HELLO")) begin
                    rep.kind = pingrx_pkg::KIND_HELLO;
                end
                else begin
                    rep.kind = pingrx_pkg::KIND_OTHER;
                end
            end
            rep.good  = good_cnt;
            rep.bad   = bad_cnt;
            rep.pings = ping_cnt;
            rep.pongs = pong_cnt;
            reports_due.push_back(rep);
            clear_line();
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: %s mismatch: expected 0x%08h, got 0x%08h",
                             $realtime, field, want, got);
            end
        endfunction

        // Check one accepted report against the oldest expectation
        function void check_report(logic [2:0] user, logic [159:0] data);
            line_report_t want;
            if (reports_due.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: unexpected report, kind %0d seq 0x%08h",
                             $realtime, user, data[31:0]);
                return;
            end
            want = reports_due.pop_front();
            compare_field("line_kind",  32'(want.kind), 32'(user));
            compare_field("seq_number", want.seq,       data[31:0]);
            compare_field("good_lines", want.good,      data[63:32]);
            compare_field("bad_lines",  want.bad,       data[95:64]);
            compare_field("pings_seen", want.pings,     data[127:96]);
            compare_field("pongs_seen", want.pongs,     data[159:128]);
        endfunction

        function int pending();
            return reports_due.size();
        endfunction

        // Count reports that never arrived
        function void close_out();
            while (reports_due.size() != 0) begin
                void'(reports_due.pop_front());
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: expected report never arrived", $realtime);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block instance
    // ------------------------------------------------------------------------
    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;     // [7:0] rx_byte
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [159:0] m_tdata;     // [31:0] seq_number, [63:32] good_lines,
                               // [95:64] bad_lines, [127:96] pings_seen,
                               // [159:128] pongs_seen
    logic [2:0]   m_tuser;     // [2:0] line_kind

    line_scoreboard sb = new();

    pingrx_pkg::byte_t line_buf [$];
    bit                gaps_on;
    int                burst_left;
    int                idle_cycles = 0;
    int                long_lines;
    int                rx_mode = 0;
    int                rx_left = 0;
    int                rx_tick = 0;

    string near_words [8] = '{"PIN", "PINGS", "PONG", "PONGO 5", "HELL", "hello",
                              "Ping 3", "PING\t9"};
    string edge_numbers [5] = '{"4294967295", "4294967296", "4294967294",
                                "0000000000042", "9999999999"};

    ping_line_receiver DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // Monitor: check reports first, then note the input transaction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_report(m_tuser, m_tdata);
            if (s_tvalid && s_tready)
                sb.note_rx_byte(s_tdata);
        end
    end

    // Watchdog: end the run after too many cycles without any transaction
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Receiver stalls: switch between a few ready patterns every so often
    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(64, 256);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (rx_tick % 12 == 0);
            default: m_tready <= ($urandom_range(0, 4) != 0);
        endcase
    end

    // ------------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------------
    task automatic send_byte(input pingrx_pkg::byte_t b);
        int gap;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        // Insert a gap between bursts
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                gap        = $urandom_range(1, 8);
                burst_left = $urandom_range(1, 20);
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(pingrx_pkg::byte_t'(s[i]));
    endtask

    // Hold the sender until every expected report has arrived
    task automatic wait_for_reports();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Random line construction
    // ------------------------------------------------------------------------
    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(pingrx_pkg::byte_t'(s[i]));
    endfunction

    function automatic pingrx_pkg::byte_t pick_blank();
        case ($urandom_range(0, 2))
            0: return pingrx_pkg::CH_SPACE;
            1: return pingrx_pkg::CH_TAB;
            default: return pingrx_pkg::CH_CR;
        endcase
    endfunction

    function automatic pingrx_pkg::byte_t pick_digit();
        return pingrx_pkg::byte_t'($urandom_range(pingrx_pkg::CH_ZERO, pingrx_pkg::CH_NINE));
    endfunction

    function automatic pingrx_pkg::byte_t pick_printable();
        return pingrx_pkg::byte_t'($urandom_range(pingrx_pkg::CH_SPACE,
                                                  pingrx_pkg::CH_TILDE));
    endfunction

    // Number text: blanks, optional sign, digits or none, optional junk after
    function automatic void put_number();
        int n;
        int sign;
        int style;
        n = $urandom_range(0, 2);
        repeat (n) line_buf.push_back(pick_blank());
        sign = $urandom_range(0, 3);
        if (sign == 0)
            line_buf.push_back(pingrx_pkg::CH_PLUS);
        else if (sign == 1)
            line_buf.push_back(pingrx_pkg::CH_MINUS);
        style = $urandom_range(0, 9);
        if (style >= 1 && style <= 6)
        begin
            n = $urandom_range(1, 5);
            repeat (n) line_buf.push_back(pick_digit());
        end
        else if (style == 7)
            put_text(edge_numbers[$urandom_range(0, 4)]);
        else if (style == 8)
        begin
            n = $urandom_range(11, 14);
            repeat (n) line_buf.push_back(pick_digit());
        end
        else if (style == 9)
        begin
            line_buf.push_back(pingrx_pkg::byte_t'($urandom_range(pingrx_pkg::CH_ZERO + 1,
                                                                  pingrx_pkg::CH_ZERO + 4)));
            repeat (9) line_buf.push_back(pick_digit());
        end
        if ($urandom_range(0, 4) == 0)
        begin
            line_buf.push_back(pick_printable());
            line_buf.push_back(pick_digit());
        end
    endfunction

    function automatic void build_random_line();
        int                pick;
        int                n;
        pingrx_pkg::byte_t b;
        line_buf.delete();
        pick = $urandom_range(0, 99);
        if (pick < 20)
        begin
            put_text("PING ");
            put_number();
        end
        else if (pick < 28)
            put_text("PING");
        else if (pick < 48)
        begin
            put_text("PONG ");
            put_number();
        end
        else if (pick < 56)
        begin
            put_text("HELLO");
            n = $urandom_range(0, 8);
            repeat (n) line_buf.push_back(pick_printable());
        end
        else if (pick < 66)
        begin
            put_text(near_words[$urandom_range(0, 7)]);
            if ($urandom_range(0, 1))
                put_number();
        end
        else if (pick < 76 || (pick >= 97 && long_lines >= 2))
        begin
            n = $urandom_range(0, 40);
            repeat (n)
                line_buf.push_back(($urandom_range(0, 9) == 0) ? pick_blank()
                                                               : pick_printable());
        end
        else if (pick < 86)
        begin
            // Noise over the whole byte range
            n = $urandom_range(1, 30);
            repeat (n)
            begin
                b = pingrx_pkg::byte_t'($urandom_range(0, 255));
                line_buf.push_back((b == pingrx_pkg::CH_LF) ? pingrx_pkg::CH_TILDE + 8'd1 : b);
            end
        end
        else if (pick < 92)
        begin
            // Blank-only line
            n = $urandom_range(0, 4);
            repeat (n)
                line_buf.push_back($urandom_range(0, 1) ? pingrx_pkg::CH_SPACE
                                                        : pingrx_pkg::CH_CR);
        end
        else if (pick < 97)
        begin
            // Well-formed ping or pong spoiled by one control byte
            put_text($urandom_range(0, 1) ? "PING " : "PONG ");
            put_number();
            b = $urandom_range(0, 1)
                ? pingrx_pkg::byte_t'($urandom_range(0, pingrx_pkg::CH_SPACE - 1))
                : pingrx_pkg::byte_t'($urandom_range(pingrx_pkg::CH_TILDE + 1, 255));
            if (b == pingrx_pkg::CH_LF || b == pingrx_pkg::CH_TAB || b == pingrx_pkg::CH_CR)
                b = pingrx_pkg::CH_TILDE + 8'd1;
            line_buf.insert($urandom_range(0, line_buf.size()), b);
        end
        else
        begin
            // Line around the storage limit
            long_lines++;
            n = $urandom_range(pingrx_pkg::LINE_MAX_DEFAULT - 5,
                               pingrx_pkg::LINE_MAX_DEFAULT + 5);
            repeat (n) line_buf.push_back(pick_printable());
        end
        // Trailing blanks to be trimmed
        if ($urandom_range(0, 9) < 3)
        begin
            n = $urandom_range(1, 3);
            repeat (n)
                line_buf.push_back($urandom_range(0, 1) ? pingrx_pkg::CH_SPACE
                                                        : pingrx_pkg::CH_CR);
        end
        line_buf.push_back(pingrx_pkg::CH_LF);
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int  sent;
        bit  paused;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        burst_left  = 0;
        gaps_on     = 1'b1;
        long_lines  = 0;
        sent        = 0;
        paused      = 1'b0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed lines: keywords, number edges, trimming, bad and long lines
        send_text("PING\n");
        send_text("PING 42\n");
        send_text("PONG 4294967295\n");
        send_text("PONG 4294967296\n");
        send_text("PONG -1\n");
        send_text("PONG  \t+17x\r \n");
        send_text("PONG -\n");
        send_text("PING 7 \r\n");
        send_text("HELLO there\n");
        send_text("hello\n");
        send_text("PINGX 5\n");
        send_text("PONG\n");
        send_text("~ \t\n");
        send_text("\r  \r\n");
        send_byte(pingrx_pkg::CH_LF);
        send_byte(8'h00);
        send_byte(pingrx_pkg::CH_LF);
        send_text("AB");
        send_byte(8'hFF);
        send_text("C\n");
        repeat (pingrx_pkg::LINE_MAX_DEFAULT) send_text("A");
        send_byte(pingrx_pkg::CH_LF);
        repeat (pingrx_pkg::LINE_MAX_DEFAULT + 1) send_text("A");
        send_byte(pingrx_pkg::CH_LF);

        wait_for_reports();

        // Random lines, with a full pause about halfway through
        while (sent < RANDOM_BYTES)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            build_random_line();
            foreach (line_buf[i])
                send_byte(line_buf[i]);
            sent += line_buf.size();
            if (!paused && sent >= RANDOM_BYTES / 2)
            begin
                paused = 1'b1;
                wait_for_reports();
            end
        end

        // Drain and let the pipeline settle
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        sb.close_out();

        if (sb.fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
